// ===== rtl/bemb_pkg.sv =====
// Shared types, codes and step tables of the braille emboss sequencer.
package bemb_pkg;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_LINE_BEGIN   = 4'd1,
    PH_MARGIN       = 4'd2,
    PH_BIT          = 4'd3,
    PH_STRIKE_HIGH  = 4'd4,
    PH_STRIKE_LOW   = 4'd5,
    PH_GAP          = 4'd6,
    PH_RETURN_CHECK = 4'd7,
    PH_RETURN_MOVE  = 4'd8,
    PH_FEED         = 4'd9,
    PH_HOME_CHECK   = 4'd10,
    PH_HOME_MOVE    = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    SEL_CAR_RIGHT = 2'd0,
    SEL_CAR_LEFT  = 2'd1,
    SEL_ROLL_UP   = 2'd2,
    SEL_ROLL_DOWN = 2'd3
  } move_sel_t;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_START = 2'd2,
    ACT_HOME  = 2'd3
  } action_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_STEPS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NARROW_GAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_GAP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_FEED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_FEED     = 3'd6;

  localparam logic [15:0] RST_STEP_TICKS   = 16'd50;
  localparam logic [15:0] RST_STRIKE_TICKS = 16'd100;
  localparam logic [7:0]  RST_MARGIN_STEPS = 8'd15;
  localparam logic [7:0]  RST_NARROW_GAP   = 8'd3;
  localparam logic [7:0]  RST_WIDE_GAP     = 8'd6;
  localparam logic [7:0]  RST_LINE_FEED    = 8'd40;
  localparam logic [7:0]  RST_ROW_FEED     = 8'd70;

  localparam logic [2:0] LAST_BIT = 3'd7;

  // half-step patterns, both nibbles carry the same coil code
  function automatic logic [7:0] step_fwd(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = 8'h77;
      3'd1: v = 8'h33;
      3'd2: v = 8'hbb;
      3'd3: v = 8'h99;
      3'd4: v = 8'hdd;
      3'd5: v = 8'hcc;
      3'd6: v = 8'hee;
      3'd7: v = 8'h66;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] step_rev(input logic [2:0] idx);
    return step_fwd(3'd7 - idx);
  endfunction

  // Put one half-step entry on the carriage (low) or roller (high) nibble.
  function automatic logic [7:0] apply_step(input logic [7:0] port,
                                            input move_sel_t sel,
                                            input logic [2:0] idx);
    logic [7:0] v;
    logic [7:0] res;
    if (sel == SEL_CAR_RIGHT || sel == SEL_ROLL_DOWN) begin
      v = step_rev(idx);
    end else begin
      v = step_fwd(idx);
    end
    if (sel == SEL_CAR_RIGHT || sel == SEL_CAR_LEFT) begin
      res = {port[7:4], v[3:0]};
    end else begin
      res = {v[7:4], port[3:0]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/braille_emboss_sequencer.sv =====
// Braille embosser sequencer: page store, motor/striker stepping, stream ports.
//
// Usage: the host sends beats on in_*; in_tuser is the action (tick, load page
// byte, start page, home carriage). Loads, start and home are taken only while
// no sequence runs; after start or home every tick beat advances the sequence
// by one tick. Each accepted beat gives exactly one result beat on out_* with
// the motor port, striker drive, busy and a one-beat done flag.
// Registers are written over cfg_* at any cycle (cfg_ready stays high) and
// should change only while the block is idle.
// A result passes through the input register and then the result register.
// Throughput: one beat per cycle while in_tready is high. A tick that runs
// through steps that take no tick time (zero-length moves, clear bits, sensor
// checks, motors off) takes an extra step-engine pass per step, with in_tready low.
// Page bytes are read from a small synchronous RAM addressed by a running
// byte position, so the byte is in the read register when a bit step needs it.
// Reset (rst_n low, synchronous) loads the register defaults, stops any
// sequence and clears the motor port; page bytes stay undefined until loaded.
// A stalled receiver holds the result register; the block then takes one more
// beat into its input register and stops with in_tready low.
module braille_emboss_sequencer #(
  parameter int BYTES_PER_LINE = 3,
  parameter int PAGE_LINES     = 9,
  parameter int PAGE_STORE     = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [4:0] byte_index, [12:5] byte_value, [13] carriage_away, [15:14] zero
  input  logic [15:0]                       in_tdata,
  // [1:0] action
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] motor_port, [8] striker, [9] busy_res, [10] done_res, [15:11] zero
  output logic [15:0]                       out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bemb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bemb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bemb_pkg::*;

  localparam int LW = $clog2(PAGE_LINES + 1);
  localparam int BW = $clog2(BYTES_PER_LINE + 1);
  localparam int AW = $clog2(PAGE_STORE);

  // configuration
  logic [15:0] step_ticks_r, strike_ticks_r;
  logic [7:0]  margin_r, narrow_r, wide_r, line_feed_r, row_feed_r;

  // input register
  logic        pend_r;
  action_t     act_r;
  logic [4:0]  bidx_r;
  logic [7:0]  bval_r;
  logic        away_r;

  // output register
  logic        out_valid_r;
  logic [10:0] out_data_r;

  // sequencer state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  port_r, port_nxt;
  logic        strike_r, strike_nxt;
  logic [LW-1:0] line_r, line_nxt;
  logic [1:0]  grp_r, grp_nxt;
  logic [BW-1:0] byte_r, byte_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [7:0]  cyc_r, cyc_nxt;
  logic [2:0]  hsi_r, hsi_nxt;
  logic [15:0] tick_r, tick_nxt;
  move_sel_t   sel_r, sel_nxt;

  logic [7:0]  page_mem [PAGE_STORE];
  logic [7:0]  rd_r;

  // step engine results
  logic        run;
  logic        consumed;
  logic        step_final;
  logic        mem_we;
  logic        done_s;
  logic        out_free;
  logic        adv_en;
  logic        in_acc;

  // helpers
  logic [15:0] hold_step, hold_strike;
  logic [2:0]  hsi_inc;
  logic [7:0]  cyc_dec;
  logic        cm_go;
  logic [15:0] cm_tick;
  logic [2:0]  cm_hsi;
  logic [7:0]  cm_cyc;
  logic [7:0]  cm_port;
  logic [7:0]  gap_n;
  logic [BW-1:0] byte_inc;
  logic [LW-1:0] line_inc;
  logic        mv_req;
  logic [7:0]  mv_n;
  move_sel_t   mv_sel;
  logic [7:0]  mv_base;
  logic        do_gap, do_after_gap, do_after_feed;

  assign cfg_ready = 1'b1;

  // next state of the sequencer, one step per cycle while adv_en is set
  always_comb begin
    hold_step   = (step_ticks_r == 16'd0) ? 16'd0 : step_ticks_r - 16'd1;
    hold_strike = (strike_ticks_r == 16'd0) ? 16'd0 : strike_ticks_r - 16'd1;
    hsi_inc     = hsi_r + 3'd1;
    cyc_dec     = (cyc_r != 8'd0) ? cyc_r - 8'd1 : cyc_r;
    gap_n       = bit_r[0] ? narrow_r : wide_r;
    byte_inc    = byte_r + BW'(1);
    line_inc    = line_r + LW'(1);

    // continue the running move
    cm_go   = 1'b1;
    cm_tick = tick_r;
    cm_hsi  = hsi_r;
    cm_cyc  = cyc_r;
    cm_port = port_r;
    if (tick_r != 16'd0) begin
      cm_tick = tick_r - 16'd1;
    end else if (hsi_inc == 3'd0 && cyc_dec == 8'd0) begin
      cm_go  = 1'b0;
      cm_hsi = hsi_inc;
      cm_cyc = cyc_dec;
    end else begin
      cm_hsi  = hsi_inc;
      cm_cyc  = (hsi_inc == 3'd0) ? cyc_dec : cyc_r;
      cm_port = apply_step(port_r, sel_r, hsi_inc);
      cm_tick = hold_step;
    end

    phase_nxt  = phase_r;
    port_nxt   = port_r;
    strike_nxt = strike_r;
    line_nxt   = line_r;
    grp_nxt    = grp_r;
    byte_nxt   = byte_r;
    bit_nxt    = bit_r;
    pos_nxt    = pos_r;
    cyc_nxt    = cyc_r;
    hsi_nxt    = hsi_r;
    tick_nxt   = tick_r;
    sel_nxt    = sel_r;

    consumed      = 1'b0;
    mem_we        = 1'b0;
    mv_req        = 1'b0;
    mv_n          = 8'd0;
    mv_sel        = SEL_CAR_RIGHT;
    mv_base       = port_r;
    do_gap        = 1'b0;
    do_after_gap  = 1'b0;
    do_after_feed = 1'b0;

    run = pend_r && act_r == ACT_TICK && phase_r != PH_IDLE;

    if (pend_r && phase_r == PH_IDLE) begin
      unique case (act_r)
        ACT_LOAD: begin
          mem_we = int'(bidx_r) < PAGE_STORE;
        end
        ACT_START: begin
          line_nxt  = '0;
          grp_nxt   = 2'd0;
          byte_nxt  = '0;
          bit_nxt   = LAST_BIT;
          pos_nxt   = '0;
          phase_nxt = PH_LINE_BEGIN;
        end
        ACT_HOME: begin
          phase_nxt = PH_HOME_CHECK;
        end
        ACT_TICK: begin
        end
        default: begin
        end
      endcase
    end

    if (run) begin
      unique case (phase_r)
        PH_LINE_BEGIN: begin
          port_nxt = 8'd0;
          byte_nxt = '0;
          bit_nxt  = LAST_BIT;
          if (margin_r != 8'd0) begin
            mv_req    = 1'b1;
            mv_n      = margin_r;
            mv_sel    = SEL_CAR_RIGHT;
            mv_base   = 8'd0;
            phase_nxt = PH_MARGIN;
          end else begin
            phase_nxt = PH_BIT;
          end
        end
        PH_MARGIN: begin
          tick_nxt = cm_tick;
          hsi_nxt  = cm_hsi;
          cyc_nxt  = cm_cyc;
          port_nxt = cm_port;
          consumed = cm_go;
          if (!cm_go) begin
            phase_nxt = PH_BIT;
          end
        end
        PH_BIT: begin
          if (rd_r[bit_r]) begin
            strike_nxt = 1'b1;
            tick_nxt   = hold_strike;
            phase_nxt  = PH_STRIKE_HIGH;
            consumed   = 1'b1;
          end else begin
            do_gap = 1'b1;
          end
        end
        PH_STRIKE_HIGH: begin
          consumed = 1'b1;
          if (tick_r != 16'd0) begin
            tick_nxt = tick_r - 16'd1;
          end else begin
            strike_nxt = 1'b0;
            tick_nxt   = hold_strike;
            phase_nxt  = PH_STRIKE_LOW;
          end
        end
        PH_STRIKE_LOW: begin
          if (tick_r != 16'd0) begin
            tick_nxt = tick_r - 16'd1;
            consumed = 1'b1;
          end else begin
            do_gap = 1'b1;
          end
        end
        PH_GAP: begin
          tick_nxt     = cm_tick;
          hsi_nxt      = cm_hsi;
          cyc_nxt      = cm_cyc;
          port_nxt     = cm_port;
          consumed     = cm_go;
          do_after_gap = !cm_go;
        end
        PH_RETURN_CHECK: begin
          if (away_r) begin
            mv_req    = 1'b1;
            mv_n      = 8'd1;
            mv_sel    = SEL_CAR_LEFT;
            phase_nxt = PH_RETURN_MOVE;
          end else begin
            port_nxt  = 8'd0;
            phase_nxt = PH_FEED;
            mv_n      = (grp_r == 2'd2) ? row_feed_r : line_feed_r;
            if (mv_n != 8'd0) begin
              mv_req  = 1'b1;
              mv_sel  = SEL_ROLL_UP;
              mv_base = 8'd0;
            end else begin
              do_after_feed = 1'b1;
            end
          end
        end
        PH_RETURN_MOVE: begin
          tick_nxt = cm_tick;
          hsi_nxt  = cm_hsi;
          cyc_nxt  = cm_cyc;
          port_nxt = cm_port;
          consumed = cm_go;
          if (!cm_go) begin
            phase_nxt = PH_RETURN_CHECK;
          end
        end
        PH_FEED: begin
          tick_nxt      = cm_tick;
          hsi_nxt       = cm_hsi;
          cyc_nxt       = cm_cyc;
          port_nxt      = cm_port;
          consumed      = cm_go;
          do_after_feed = !cm_go;
        end
        PH_HOME_CHECK: begin
          if (away_r) begin
            mv_req    = 1'b1;
            mv_n      = 8'd1;
            mv_sel    = SEL_CAR_LEFT;
            phase_nxt = PH_HOME_MOVE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_HOME_MOVE: begin
          tick_nxt = cm_tick;
          hsi_nxt  = cm_hsi;
          cyc_nxt  = cm_cyc;
          port_nxt = cm_port;
          consumed = cm_go;
          if (!cm_go) begin
            phase_nxt = PH_HOME_CHECK;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // a gap after a bit, unless its length is zero
      if (do_gap) begin
        if (gap_n != 8'd0) begin
          mv_req    = 1'b1;
          mv_n      = gap_n;
          mv_sel    = SEL_CAR_RIGHT;
          phase_nxt = PH_GAP;
        end else begin
          do_after_gap = 1'b1;
        end
      end

      if (mv_req) begin
        cyc_nxt  = mv_n;
        hsi_nxt  = 3'd0;
        sel_nxt  = mv_sel;
        port_nxt = apply_step(mv_base, mv_sel, 3'd0);
        tick_nxt = hold_step;
        consumed = 1'b1;
      end

      if (do_after_gap) begin
        if (bit_r != 3'd0) begin
          bit_nxt   = bit_r - 3'd1;
          phase_nxt = PH_BIT;
        end else begin
          byte_nxt = byte_inc;
          pos_nxt  = (pos_r == AW'(PAGE_STORE - 1)) ? '0 : pos_r + AW'(1);
          if (byte_inc >= BW'(BYTES_PER_LINE)) begin
            phase_nxt = PH_RETURN_CHECK;
          end else begin
            bit_nxt   = LAST_BIT;
            phase_nxt = PH_BIT;
          end
        end
      end

      if (do_after_feed) begin
        line_nxt = line_inc;
        grp_nxt  = (grp_r == 2'd2) ? 2'd0 : grp_r + 2'd1;
        if (line_inc >= LW'(PAGE_LINES)) begin
          port_nxt  = 8'd0;
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_LINE_BEGIN;
        end
      end
    end
  end

  // handshake and result side
  always_comb begin
    step_final = !run || consumed || phase_nxt == PH_IDLE;
    done_s     = run && phase_nxt == PH_IDLE;
    out_free   = !out_valid_r || out_tready;
    adv_en     = pend_r && (!step_final || out_free);
    in_tready  = !pend_r || (step_final && out_free);
    in_acc     = in_tvalid && in_tready;
    out_tvalid = out_valid_r;
    out_tdata  = {5'd0, out_data_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r   <= RST_STEP_TICKS;
      strike_ticks_r <= RST_STRIKE_TICKS;
      margin_r       <= RST_MARGIN_STEPS;
      narrow_r       <= RST_NARROW_GAP;
      wide_r         <= RST_WIDE_GAP;
      line_feed_r    <= RST_LINE_FEED;
      row_feed_r     <= RST_ROW_FEED;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STEP_TICKS:   step_ticks_r   <= cfg_data;
        CFG_STRIKE_TICKS: strike_ticks_r <= cfg_data;
        CFG_MARGIN_STEPS: margin_r       <= cfg_data[7:0];
        CFG_NARROW_GAP:   narrow_r       <= cfg_data[7:0];
        CFG_WIDE_GAP:     wide_r         <= cfg_data[7:0];
        CFG_LINE_FEED:    line_feed_r    <= cfg_data[7:0];
        CFG_ROW_FEED:     row_feed_r     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      port_r      <= 8'd0;
      strike_r    <= 1'b0;
      line_r      <= '0;
      grp_r       <= 2'd0;
      byte_r      <= '0;
      bit_r       <= LAST_BIT;
      pos_r       <= '0;
      cyc_r       <= 8'd0;
      hsi_r       <= 3'd0;
      tick_r      <= 16'd0;
      sel_r       <= SEL_CAR_RIGHT;
    end else begin
      if (in_acc) begin
        pend_r <= 1'b1;
      end else if (adv_en && step_final) begin
        pend_r <= 1'b0;
      end
      if (adv_en && step_final) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (adv_en) begin
        phase_r  <= phase_nxt;
        port_r   <= port_nxt;
        strike_r <= strike_nxt;
        line_r   <= line_nxt;
        grp_r    <= grp_nxt;
        byte_r   <= byte_nxt;
        bit_r    <= bit_nxt;
        pos_r    <= pos_nxt;
        cyc_r    <= cyc_nxt;
        hsi_r    <= hsi_nxt;
        tick_r   <= tick_nxt;
        sel_r    <= sel_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= action_t'(in_tuser);
      bidx_r <= in_tdata[4:0];
      bval_r <= in_tdata[12:5];
      away_r <= in_tdata[13];
    end
    if (adv_en && step_final) begin
      out_data_r <= {done_s, phase_nxt != PH_IDLE, strike_nxt, port_nxt};
    end
  end

  // page store; the read register loads from the next byte position, so it updates along with pos_r
  always_ff @(posedge clk) begin
    if (adv_en && mem_we) begin
      page_mem[AW'(bidx_r)] <= bval_r;
    end
    rd_r <= page_mem[adv_en ? pos_nxt : pos_r];
  end

endmodule
